// ----- sv/us2x_pkg.sv -----
// shared types and constants of the 2x interpolating upsampler
package us2x_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int VALUE_W         = 16;
    localparam int COORD_W         = 11;
    localparam int CFG_DATA_W      = 11;
    localparam int CFG_IDX_W       = 1;
    localparam int ROW_W           = 10;
    localparam int COL_W           = 11;
    localparam int MAX_ROWS        = 1024;
    localparam int DIM_RESET       = 1024;
    localparam int MAX_COLS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b1;

    // result currently emitted for one input sample
    typedef enum logic [1:0] {
        PH_COPY,
        PH_HORZ,
        PH_VERT,
        PH_CENT
    } t_phase;

    // one classified sample with all its candidate results
    typedef struct packed {
        logic [VALUE_W-1:0] cur;
        logic [VALUE_W-1:0] horz;
        logic [VALUE_W-1:0] vert;
        logic [VALUE_W-1:0] cent;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               has_h;
        logic               has_v;
        logic               last_frame;
    } t_job;

endpackage

// ----- sv/us2x_if.sv -----
// stream and configuration channel interfaces of the upsampler
interface us2x_in_if;
    logic                          valid;
    logic                          ready;
    logic [us2x_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface us2x_out_if;
    logic                         valid;
    logic                         ready;
    logic [us2x_pkg::VALUE_W-1:0] value;
    logic [us2x_pkg::COORD_W-1:0] out_row;
    logic [us2x_pkg::COORD_W-1:0] out_col;
    logic                         last_of_run;
    logic                         frame_done;

    modport source (output valid, output value, output out_row, output out_col,
                    output last_of_run, output frame_done, input ready);
    modport sink   (input valid, input value, input out_row, input out_col,
                    input last_of_run, input frame_done, output ready);
endinterface

interface us2x_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [us2x_pkg::CFG_IDX_W-1:0]  index;
    logic [us2x_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/us2x_front.sv -----
// front end: position tracking, line store and classification of each sample
module us2x_front #(
    parameter int MAX_COLS    = us2x_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS = us2x_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [us2x_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [us2x_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [us2x_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_push,
    output us2x_pkg::t_job                  o_job,
    input  logic                            i_q_ready
);

    localparam int SW = (SAMPLE_BITS < us2x_pkg::SAMPLE_W) ? SAMPLE_BITS : us2x_pkg::SAMPLE_W;
    localparam int AW = $clog2(MAX_COLS);

    logic [us2x_pkg::CFG_DATA_W-1:0] r_num_cols, r_num_rows;
    logic [us2x_pkg::COL_W-1:0]      r_col;
    logic [us2x_pkg::ROW_W-1:0]      r_row;
    logic [SW-1:0]                   r_left;
    logic [SW-1:0]                   r_above_left;
    logic                            r_s1_valid;
    logic [SW-1:0]                   r_s1_cur, r_s1_left;
    logic [us2x_pkg::ROW_W-1:0]      r_s1_row;
    logic [us2x_pkg::COL_W-1:0]      r_s1_col;
    logic                            r_s1_last;
    logic [SW-1:0]                   r_rd;
    logic [SW-1:0]                   r_mem [MAX_COLS];

    logic [us2x_pkg::CFG_DATA_W-1:0] cols_eff, rows_eff;
    logic                            col_last, row_last;
    logic                            accept, push;
    logic [SW-1:0]                   cur, above;
    logic [AW-1:0]                   addr;
    logic [SW:0]                     h_sum, v_sum, ha_sum, c_sum;
    logic [SW-1:0]                   h_mean, v_mean, ha_mean;

    // clamp the dimension registers to their usable range
    always_comb begin
        if (r_num_cols == '0) begin
            cols_eff = us2x_pkg::CFG_DATA_W'(1);
        end else if (32'(r_num_cols) > MAX_COLS) begin
            cols_eff = us2x_pkg::CFG_DATA_W'(MAX_COLS);
        end else begin
            cols_eff = r_num_cols;
        end
        if (r_num_rows == '0) begin
            rows_eff = us2x_pkg::CFG_DATA_W'(1);
        end else if (32'(r_num_rows) > us2x_pkg::MAX_ROWS) begin
            rows_eff = us2x_pkg::CFG_DATA_W'(us2x_pkg::MAX_ROWS);
        end else begin
            rows_eff = r_num_rows;
        end
    end

    assign col_last    = (12'(r_col) + 12'd1) == 12'(cols_eff);
    assign row_last    = (11'(r_row) + 11'd1) == 11'(rows_eff);
    assign push        = r_s1_valid && i_q_ready;
    assign o_in_ready  = !r_s1_valid || i_q_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_push      = push;
    assign cur         = SW'(i_sample);
    assign addr        = AW'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols   <= us2x_pkg::CFG_DATA_W'(us2x_pkg::DIM_RESET);
            r_num_rows   <= us2x_pkg::CFG_DATA_W'(us2x_pkg::DIM_RESET);
            r_col        <= '0;
            r_row        <= '0;
            r_left       <= '0;
            r_above_left <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    us2x_pkg::REG_NUM_COLS: r_num_cols <= i_cfg_data;
                    us2x_pkg::REG_NUM_ROWS: r_num_rows <= i_cfg_data;
                    default: ;
                endcase
                // any register write restarts the frame
                r_col        <= '0;
                r_row        <= '0;
                r_left       <= '0;
                r_above_left <= '0;
            end else begin
                if (accept) begin
                    if (col_last) begin
                        r_col  <= '0;
                        r_left <= '0;
                        r_row  <= row_last ? '0 : r_row + 1'b1;
                    end else begin
                        r_col  <= r_col + 1'b1;
                        r_left <= cur;
                    end
                end
                if (push) begin
                    r_above_left <= above;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cur  <= cur;
            r_s1_left <= r_left;
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_s1_last <= row_last && col_last;
        end
    end

    // line store: old entry read out as the new sample goes in
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd        <= r_mem[addr];
            r_mem[addr] <= cur;
        end
    end

    always_comb begin
        above   = (r_s1_row != '0) ? r_rd : '0;
        h_sum   = {1'b0, r_s1_left} + {1'b0, r_s1_cur};
        v_sum   = {1'b0, above} + {1'b0, r_s1_cur};
        ha_sum  = {1'b0, r_above_left} + {1'b0, above};
        h_mean  = h_sum[SW:1];
        v_mean  = v_sum[SW:1];
        ha_mean = ha_sum[SW:1];
        c_sum   = {1'b0, ha_mean} + {1'b0, h_mean};

        o_job.cur        = us2x_pkg::VALUE_W'(r_s1_cur);
        o_job.horz       = us2x_pkg::VALUE_W'(h_mean);
        o_job.vert       = us2x_pkg::VALUE_W'(v_mean);
        o_job.cent       = us2x_pkg::VALUE_W'(c_sum[SW:1]);
        o_job.row        = r_s1_row;
        o_job.col        = r_s1_col;
        o_job.has_h      = r_s1_col != '0;
        o_job.has_v      = r_s1_row != '0;
        o_job.last_frame = r_s1_last;
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        12'(r_col) < 12'(cols_eff))
        else $error("column counter beyond row length");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        11'(r_row) < 11'(rows_eff))
        else $error("row counter beyond frame height");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !i_q_ready |=> r_s1_valid && $stable(r_s1_col) && $stable(r_s1_row))
        else $error("stalled sample lost its position");

endmodule

// ----- sv/us2x_queue.sv -----
// short job queue between front end and result sequencer
module us2x_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  us2x_pkg::t_job i_job,
    output logic           o_ready,
    output logic           o_valid,
    output us2x_pkg::t_job o_job,
    input  logic           i_pop
);

    localparam int PW = (us2x_pkg::QUEUE_DEPTH > 1) ? $clog2(us2x_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(us2x_pkg::QUEUE_DEPTH + 1);

    us2x_pkg::t_job r_mem [us2x_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_ready = r_count != CW'(us2x_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(us2x_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(us2x_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- sv/us2x_back.sv -----
// back end: walks the present results of each job, one beat per cycle while the receiver is ready
module us2x_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  us2x_pkg::t_job               i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [us2x_pkg::VALUE_W-1:0] o_value,
    output logic [us2x_pkg::COORD_W-1:0] o_out_row,
    output logic [us2x_pkg::COORD_W-1:0] o_out_col,
    output logic                         o_last_of_run,
    output logic                         o_frame_done
);

    us2x_pkg::t_phase             r_phase, n_phase, step_phase;
    logic                         r_job_valid, n_job_valid;
    us2x_pkg::t_job               r_job;
    logic                         r_out_valid;
    logic [us2x_pkg::VALUE_W-1:0] r_out_value;
    logic [us2x_pkg::COORD_W-1:0] r_out_row, r_out_col;
    logic                         r_out_last, r_out_done;

    logic                         advance, is_last, load;
    logic [us2x_pkg::VALUE_W-1:0] res_value;
    logic [us2x_pkg::COORD_W-1:0] row2, res_row, res_col;
    logic [us2x_pkg::COL_W:0]     col2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= us2x_pkg::PH_COPY;
            r_job_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_job_valid <= n_job_valid;
        end
    end

    always_comb begin
        advance    = r_job_valid && (!r_out_valid || i_ready);
        is_last    = 1'b0;
        step_phase = r_phase;
        // order of results: copy, horizontal, vertical, centre
        unique case (r_phase)
            us2x_pkg::PH_COPY: begin
                if (r_job.has_h) begin
                    step_phase = us2x_pkg::PH_HORZ;
                end else if (r_job.has_v) begin
                    step_phase = us2x_pkg::PH_VERT;
                end else begin
                    is_last = 1'b1;
                end
            end
            us2x_pkg::PH_HORZ: begin
                if (r_job.has_v) begin
                    step_phase = us2x_pkg::PH_VERT;
                end else begin
                    is_last = 1'b1;
                end
            end
            us2x_pkg::PH_VERT: begin
                if (r_job.has_h) begin
                    step_phase = us2x_pkg::PH_CENT;
                end else begin
                    is_last = 1'b1;
                end
            end
            us2x_pkg::PH_CENT: is_last = 1'b1;
            default: is_last = 1'b1;
        endcase

        load  = i_q_valid && (!r_job_valid || (advance && is_last));
        o_pop = load;

        if (load) begin
            n_phase = us2x_pkg::PH_COPY;
        end else if (advance) begin
            n_phase = step_phase;
        end else begin
            n_phase = r_phase;
        end

        if (load) begin
            n_job_valid = 1'b1;
        end else if (advance && is_last) begin
            n_job_valid = 1'b0;
        end else begin
            n_job_valid = r_job_valid;
        end

        row2 = {r_job.row, 1'b0};
        col2 = {r_job.col, 1'b0};
        unique case (r_phase)
            us2x_pkg::PH_COPY: begin
                res_value = r_job.cur;
                res_row   = row2;
                res_col   = us2x_pkg::COORD_W'(col2);
            end
            us2x_pkg::PH_HORZ: begin
                res_value = r_job.horz;
                res_row   = row2;
                res_col   = us2x_pkg::COORD_W'(col2 - 1'b1);
            end
            us2x_pkg::PH_VERT: begin
                res_value = r_job.vert;
                res_row   = row2 - 1'b1;
                res_col   = us2x_pkg::COORD_W'(col2);
            end
            default: begin
                res_value = r_job.cent;
                res_row   = row2 - 1'b1;
                res_col   = us2x_pkg::COORD_W'(col2 - 1'b1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

    // output register lets the next job load while a beat waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_value <= res_value;
            r_out_row   <= res_row;
            r_out_col   <= res_col;
            r_out_last  <= is_last;
            r_out_done  <= is_last && r_job.last_frame;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_value       = r_out_value;
    assign o_out_row     = r_out_row;
    assign o_out_col     = r_out_col;
    assign o_last_of_run = r_out_last;
    assign o_frame_done  = r_out_done;

    a_horz_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && r_phase == us2x_pkg::PH_HORZ |-> r_job.has_h)
        else $error("horizontal mean on first column");

    a_vert_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && r_phase == us2x_pkg::PH_VERT |-> r_job.has_v)
        else $error("vertical mean on first row");

    a_cent_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && r_phase == us2x_pkg::PH_CENT |-> r_job.has_h && r_job.has_v)
        else $error("centre value without both neighbours");

endmodule

// ----- sv/upsample_2x_interpolate.sv -----
// top level of the 2x interpolating upsampler
// Takes an image in row-major order, one sample per beat, and returns the
// (2R-1) by (2C-1) upscaled image as result beats that carry their own row and
// column: the copy, then the horizontal, vertical and centre means that exist
// for that position, with last_of_run on the final beat of each sample and
// frame_done on the final beat of the frame. A sample yields one to four beats,
// one per cycle while the single result channel is ready: one on the first row and
// column, two elsewhere on the first row or column and four for any other. A
// sample enters the line store memory on the cycle it is accepted, reading the
// entry of the row above through the same port, and a two-deep job queue lets
// intake run ahead of the result side. Writing num_cols or num_rows restarts the
// frame; the user must do so only while idle, which the block does not enforce.
// The line store holds no reset state and needs no clearing pass after reset.
module upsample_2x_interpolate #(
    parameter int MAX_COLS    = us2x_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS = us2x_pkg::SAMPLE_BITS_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    us2x_in_if.sink     i_in,
    us2x_cfg_if.sink    i_cfg,
    us2x_out_if.source  o_out
);

    logic           push, q_ready, q_valid, pop;
    us2x_pkg::t_job front_job, q_job;

    us2x_front #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_sample    (i_in.sample),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_push      (push),
        .o_job       (front_job),
        .i_q_ready   (q_ready)
    );

    us2x_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    us2x_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (q_job),
        .o_pop         (pop),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_value       (o_out.value),
        .o_out_row     (o_out.out_row),
        .o_out_col     (o_out.out_col),
        .o_last_of_run (o_out.last_of_run),
        .o_frame_done  (o_out.frame_done)
    );

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench of the 2x interpolating upsampler
module testbench;

    localparam int STORE_DEPTH = us2x_pkg::MAX_COLS_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [us2x_pkg::VALUE_W-1:0] value;
        logic [us2x_pkg::COORD_W-1:0] row;
        logic [us2x_pkg::COORD_W-1:0] col;
        logic                         last_of_run;
        logic                         frame_done;
    } t_pixel;

    typedef enum logic {
        STEP_SAMPLE,
        STEP_WRITE
    } t_step_kind;

    // one directed row: a sample (optionally with its copy beat typed in) or a register write
    typedef struct packed {
        t_step_kind                     kind;
        logic [us2x_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [15:0]                    data;
        logic                           typed;
        logic [us2x_pkg::VALUE_W-1:0]   exp_value;
        logic [us2x_pkg::COORD_W-1:0]   exp_row;
        logic [us2x_pkg::COORD_W-1:0]   exp_col;
    } t_step;

    t_step dir_tbl [30] = '{
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'h1234, 1'b1, 16'h1234, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'hFFFF, 1'b1, 16'hFFFF, 11'd0, 11'd2},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'h0000, 1'b0, 16'h0000, 11'd0, 11'd0},
        // zero columns and an oversized row count are clamped
        '{STEP_WRITE,  us2x_pkg::REG_NUM_COLS, 16'd0,    1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_WRITE,  us2x_pkg::REG_NUM_ROWS, 16'd2047, 1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'hFFFF, 1'b1, 16'hFFFF, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'h0000, 1'b1, 16'h0000, 11'd2, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'hFFFF, 1'b1, 16'hFFFF, 11'd4, 11'd0},
        // full 3x2 frame with centre values, then wrap into the next frame
        '{STEP_WRITE,  us2x_pkg::REG_NUM_COLS, 16'd3,    1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_WRITE,  us2x_pkg::REG_NUM_ROWS, 16'd2,    1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'hFFFF, 1'b1, 16'hFFFF, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'hFFFF, 1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'h0000, 1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'h0001, 1'b1, 16'h0001, 11'd2, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'hFFFF, 1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'h8000, 1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'hAAAA, 1'b1, 16'hAAAA, 11'd0, 11'd0},
        '{STEP_WRITE,  us2x_pkg::REG_NUM_ROWS, 16'd0,    1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_WRITE,  us2x_pkg::REG_NUM_COLS, 16'd2,    1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'h5555, 1'b1, 16'h5555, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'hAAAA, 1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'h0000, 1'b1, 16'h0000, 11'd0, 11'd0},
        '{STEP_WRITE,  us2x_pkg::REG_NUM_COLS, 16'd1025, 1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_WRITE,  us2x_pkg::REG_NUM_ROWS, 16'd1,    1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'h8001, 1'b1, 16'h8001, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'h7FFE, 1'b1, 16'h7FFE, 11'd0, 11'd2},
        // single-sample frame
        '{STEP_WRITE,  us2x_pkg::REG_NUM_COLS, 16'd1,    1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_WRITE,  us2x_pkg::REG_NUM_ROWS, 16'd1,    1'b0, 16'h0000, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'hFFFF, 1'b1, 16'hFFFF, 11'd0, 11'd0},
        '{STEP_SAMPLE, us2x_pkg::REG_NUM_COLS, 16'h0000, 1'b1, 16'h0000, 11'd0, 11'd0}
    };

    logic i_clk;
    logic i_rst_n;

    us2x_in_if  in_if ();
    us2x_cfg_if cfg_if ();
    us2x_out_if out_if ();

    upsample_2x_interpolate u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // predictor state
    logic [us2x_pkg::CFG_DATA_W-1:0] cfg_cols;
    logic [us2x_pkg::CFG_DATA_W-1:0] cfg_rows;
    logic [us2x_pkg::VALUE_W-1:0]    line_mem [STORE_DEPTH];
    logic [us2x_pkg::VALUE_W-1:0]    left_px;
    logic [us2x_pkg::VALUE_W-1:0]    above_left_px;
    int unsigned                     row_pos;
    int unsigned                     col_pos;

    t_pixel pixel_q [$];
    t_step  sample_hint_q [$];

    int  err_count;
    int  samples_in;
    int  beats_out;
    int  frames_out;
    int  reg_writes;
    int  stall_cnt;
    int  idle_pct;
    int  stall_pct;
    bit  hold_req;
    bit  busy;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_dim(input logic [us2x_pkg::CFG_DATA_W-1:0] d,
                                              input int unsigned hi);
        if (d == 0) return 1;
        if (32'(d) > hi) return hi;
        return 32'(d);
    endfunction

    function automatic logic [us2x_pkg::VALUE_W-1:0] mean2(
        input logic [us2x_pkg::VALUE_W-1:0] a,
        input logic [us2x_pkg::VALUE_W-1:0] b);
        logic [us2x_pkg::VALUE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[us2x_pkg::VALUE_W:1];
    endfunction

    // works out the result beats of one accepted sample and advances the position
    function automatic void predict_upscaled(input logic [us2x_pkg::SAMPLE_W-1:0] smp,
                                             input t_step hint);
        int unsigned                  cols;
        int unsigned                  rows;
        int unsigned                  r;
        int unsigned                  c;
        int                           n;
        logic [us2x_pkg::VALUE_W-1:0] above;
        logic [us2x_pkg::VALUE_W-1:0] horz;
        t_pixel                       beats [4];

        cols = clamp_dim(cfg_cols, STORE_DEPTH);
        rows = clamp_dim(cfg_rows, us2x_pkg::MAX_ROWS);
        r = row_pos;
        c = col_pos;
        if (c >= cols) c = 0;
        if (r >= rows) r = 0;
        above = (r > 0) ? line_mem[c] : '0;
        horz  = mean2(left_px, smp);

        n = 0;
        beats[n] = '{smp, us2x_pkg::COORD_W'(2 * r), us2x_pkg::COORD_W'(2 * c), 1'b0, 1'b0};
        n++;
        if (hint.typed) begin
            beats[0].value = hint.exp_value;
            beats[0].row   = hint.exp_row;
            beats[0].col   = hint.exp_col;
        end
        if (c > 0) begin
            beats[n] = '{horz, us2x_pkg::COORD_W'(2 * r), us2x_pkg::COORD_W'(2 * c - 1),
                         1'b0, 1'b0};
            n++;
        end
        if (r > 0) begin
            beats[n] = '{mean2(above, smp), us2x_pkg::COORD_W'(2 * r - 1),
                         us2x_pkg::COORD_W'(2 * c), 1'b0, 1'b0};
            n++;
        end
        if (r > 0 && c > 0) begin
            beats[n] = '{mean2(mean2(above_left_px, above), horz),
                         us2x_pkg::COORD_W'(2 * r - 1), us2x_pkg::COORD_W'(2 * c - 1),
                         1'b0, 1'b0};
            n++;
        end
        beats[n-1].last_of_run = 1'b1;
        beats[n-1].frame_done  = (r + 1 == rows) && (c + 1 == cols);
        for (int k = 0; k < n; k++)
            pixel_q.push_back(beats[k]);

        above_left_px = above;
        line_mem[c]   = smp;
        left_px       = smp;
        c++;
        if (c >= cols) begin
            c = 0;
            left_px = '0;
            above_left_px = '0;
            r++;
            if (r >= rows) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    task automatic report_error(input string what, input int unsigned got,
                                input int unsigned want);
        if (err_count < 40)
            $display("%0t mismatch: %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // monitor: predictor updates, result checks and the watchdog
    always @(posedge i_clk) begin : monitor
        t_pixel want;
        t_step  hint;
        bit     moved;

        moved = 1'b0;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == us2x_pkg::REG_NUM_COLS)
                    cfg_cols = cfg_if.data;
                else if (cfg_if.index == us2x_pkg::REG_NUM_ROWS)
                    cfg_rows = cfg_if.data;
                row_pos = 0;
                col_pos = 0;
                left_px = '0;
                above_left_px = '0;
                reg_writes++;
                moved = 1'b1;
            end
            if (in_if.valid && in_if.ready) begin
                hint = '0;
                if (sample_hint_q.size() != 0) hint = sample_hint_q.pop_front();
                predict_upscaled(in_if.sample, hint);
                samples_in++;
                moved = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                beats_out++;
                if (out_if.frame_done === 1'b1) frames_out++;
                moved = 1'b1;
                if (pixel_q.size() == 0) begin
                    report_error("result beat with nothing expected", out_if.value, 0);
                end else begin
                    want = pixel_q.pop_front();
                    if (out_if.value !== want.value)
                        report_error("value", out_if.value, want.value);
                    if (out_if.out_row !== want.row)
                        report_error("out_row", out_if.out_row, want.row);
                    if (out_if.out_col !== want.col)
                        report_error("out_col", out_if.out_col, want.col);
                    if (out_if.last_of_run !== want.last_of_run)
                        report_error("last_of_run", out_if.last_of_run, want.last_of_run);
                    if (out_if.frame_done !== want.frame_done)
                        report_error("frame_done", out_if.frame_done, want.frame_done);
                end
            end
        end
        stall_cnt = moved ? 0 : stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    out_if.ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_sample(input t_step st);
        cfg_if.valid <= 1'b0;
        sample_hint_q.push_back(st);
        busy = 1'b1;
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= st.data[us2x_pkg::SAMPLE_W-1:0];
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // leaves the write valid high so that writes can follow back to back
    task automatic write_reg(input logic [us2x_pkg::CFG_IDX_W-1:0] idx,
                             input logic [us2x_pkg::CFG_DATA_W-1:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        if (busy) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
            while (pixel_q.size() != 0) @(posedge i_clk);
            busy = 1'b0;
        end
    endtask

    function automatic logic [us2x_pkg::CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return us2x_pkg::CFG_DATA_W'(us2x_pkg::DIM_RESET);
            default: return us2x_pkg::CFG_DATA_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic t_step random_sample();
        t_step st;
        st = '0;
        st.kind = STEP_SAMPLE;
        if ($urandom_range(3) == 0)
            st.data = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else
            st.data = 16'($urandom_range(65535));
        return st;
    endfunction

    initial begin : stimulus
        logic [us2x_pkg::CFG_DATA_W-1:0] cols;
        logic [us2x_pkg::CFG_DATA_W-1:0] rows;
        int                              frame_len;
        int                              n;
        int                              phase_items;

        in_if.valid   = 1'b0;
        in_if.sample  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = us2x_pkg::REG_NUM_COLS;
        cfg_if.data   = '0;
        i_rst_n       = 1'b0;
        cfg_cols      = us2x_pkg::CFG_DATA_W'(us2x_pkg::DIM_RESET);
        cfg_rows      = us2x_pkg::CFG_DATA_W'(us2x_pkg::DIM_RESET);
        left_px       = '0;
        above_left_px = '0;
        row_pos       = 0;
        col_pos       = 0;
        foreach (line_mem[k]) line_mem[k] = '0;
        err_count = 0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b0;
        busy      = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[k]) begin
            if (dir_tbl[k].kind == STEP_WRITE) begin
                drain_results();
                write_reg(dir_tbl[k].reg_idx, dir_tbl[k].data[us2x_pkg::CFG_DATA_W-1:0]);
            end else begin
                send_sample(dir_tbl[k]);
            end
        end

        // block fills up behind a long result hold-off
        drain_results();
        write_reg(us2x_pkg::REG_NUM_COLS, us2x_pkg::CFG_DATA_W'(4));
        write_reg(us2x_pkg::REG_NUM_ROWS, us2x_pkg::CFG_DATA_W'(3));
        hold_req = 1'b1;
        repeat (12) send_sample(random_sample());

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            phase_items = 0;
            while (phase_items < 15) begin
                drain_results();
                cols = pick_dim();
                rows = pick_dim();
                write_reg(us2x_pkg::REG_NUM_COLS, cols);
                write_reg(us2x_pkg::REG_NUM_ROWS, rows);
                frame_len = clamp_dim(cols, STORE_DEPTH) *
                            clamp_dim(rows, us2x_pkg::MAX_ROWS);
                // small frames run to the end and at times into the next one, big ones stay partial
                if (frame_len <= 30)
                    n = frame_len + $urandom_range(0, clamp_dim(cols, STORE_DEPTH));
                else
                    n = $urandom_range(1, 20);
                repeat (n) send_sample(random_sample());
                phase_items += n;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pixel_q.size() != 0)
            report_error("result beats never delivered", pixel_q.size(), 0);

        $display("covered %0d samples, %0d result beats, %0d finished frames, %0d register writes",
                 samples_in, beats_out, frames_out, reg_writes);
        $display("idling: none, sender, receiver and both, with one long result hold-off");
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
